[rtl/core/u8cp_pkg.sv]
`timescale 1ns / 1ps

package u8cp_pkg;

    // Lead byte ranges for the two accepted sequence lengths
    localparam logic [7:0] LEAD2_LO = 8'hC2;
    localparam logic [7:0] LEAD2_HI = 8'hDF;
    localparam logic [7:0] LEAD3_LO = 8'hE0;
    localparam logic [7:0] LEAD3_HI = 8'hEF;

    // Continuation byte pattern 10xxxxxx
    localparam logic [1:0] TAIL_MARK = 2'b10;

    // Smallest code point a 3-byte form may carry
    localparam logic [15:0] MIN_THREE = 16'd2048;

    // Pending continuation counts
    localparam logic [1:0] TAILS_NONE = 2'd0;
    localparam logic [1:0] TAILS_ONE  = 2'd1;
    localparam logic [1:0] TAILS_TWO  = 2'd2;

    localparam int SPEC_COUNT = 32;

    // Code points behind cp1252 codes 128..159; zero marks an unused code
    localparam logic [15:0] SPEC_MAP [SPEC_COUNT] = '{
        16'h20AC, 16'h0000, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h0000, 16'h017D, 16'h0000,
        16'h0000, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h0000, 16'h017E, 16'h0178
    };

    // Code point finished by the current byte
    typedef struct packed {
        logic        have;
        logic [15:0] code;
    } dec_result_t;

    // Windows-1252 character for a finished code point
    typedef struct packed {
        logic       hit;
        logic [7:0] ch;
    } map_result_t;

endpackage

[rtl/core/u8cp_decode.sv]
`timescale 1ns / 1ps

module u8cp_decode
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic [7:0]            text_byte,
    input  logic                  last_in_text,
    output u8cp_pkg::dec_result_t result
);
    import u8cp_pkg::*;

    logic [1:0]  tails_reg;
    logic [1:0]  tails_next;
    logic [15:0] partial_reg;
    logic [15:0] partial_next;
    logic        three_reg;
    logic        three_next;
    logic [15:0] shifted;
    logic [1:0]  tails_dec;

    // Hold sequence state; advance only when the request moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tails_reg   <= TAILS_NONE;
            partial_reg <= '0;
            three_reg   <= 1'b0;
        end
        else if (advance)
        begin
            tails_reg   <= tails_next;
            partial_reg <= partial_next;
            three_reg   <= three_next;
        end
    end

    assign shifted   = {partial_reg[9:0], text_byte[5:0]};
    assign tails_dec = tails_reg - 2'd1;

    // Step the sequence by one byte
    always_comb
    begin
        tails_next   = tails_reg;
        partial_next = partial_reg;
        three_next   = three_reg;
        result.have  = 1'b0;
        result.code  = '0;

        if (tails_reg == TAILS_NONE)
        begin
            if (text_byte >= LEAD2_LO && text_byte <= LEAD2_HI)
            begin
                partial_next = {11'd0, text_byte[4:0]};
                tails_next   = TAILS_ONE;
                three_next   = 1'b0;
            end
            else if (text_byte >= LEAD3_LO && text_byte <= LEAD3_HI)
            begin
                partial_next = {12'd0, text_byte[3:0]};
                tails_next   = TAILS_TWO;
                three_next   = 1'b1;
            end
            else if (!text_byte[7])
            begin
                result.have = 1'b1;
                result.code = {8'd0, text_byte};
            end
        end
        else if (text_byte[7:6] != TAIL_MARK)
        begin
            // Drop a broken sequence
            tails_next   = TAILS_NONE;
            partial_next = '0;
            three_next   = 1'b0;
        end
        else
        begin
            partial_next = shifted;
            tails_next   = tails_dec;
            if (tails_dec == TAILS_NONE)
            begin
                // Drop overlong 3-byte forms
                result.have  = !(three_reg && shifted < MIN_THREE);
                result.code  = shifted;
                partial_next = '0;
                three_next   = 1'b0;
            end
        end

        // Discard a sequence left open at the end of the text
        if (last_in_text && tails_next != TAILS_NONE)
        begin
            tails_next   = TAILS_NONE;
            partial_next = '0;
            three_next   = 1'b0;
        end
    end

endmodule

[rtl/core/u8cp_map.sv]
`timescale 1ns / 1ps

module u8cp_map
(
    input  u8cp_pkg::dec_result_t dec,
    output u8cp_pkg::map_result_t result
);
    import u8cp_pkg::*;

    // Pass printable Latin-1, else look up the cp1252 specials
    always_comb
    begin
        result.hit = 1'b0;
        result.ch  = '0;
        if ((dec.code >= 16'd32 && dec.code <= 16'd126) ||
            (dec.code >= 16'd160 && dec.code <= 16'd255))
        begin
            result.hit = dec.have;
            result.ch  = dec.code[7:0];
        end
        else
        begin
            for (int k = 0; k < SPEC_COUNT; k++)
            begin
                if (SPEC_MAP[k] != 16'd0 && dec.code == SPEC_MAP[k])
                begin
                    result.hit = dec.have;
                    result.ch  = {3'b100, 5'(k)};
                end
            end
        end
    end

endmodule

[rtl/core/utf8_to_cp1252_decoder.sv]
`timescale 1ns / 1ps

// UTF-8 to Windows-1252 stream decoder. Takes one UTF-8 byte per request and
// returns at most one Windows-1252 character (32..255) per byte, from 2-byte
// (lead C2..DF) and 3-byte (lead E0..EF) sequences and plain ASCII; stray,
// broken, overlong and unmappable input produces nothing, and a sequence open
// at a byte marked last_in_text is discarded. The block accepts one byte every
// cycle unless its output is stalled: a byte sits in the input register while
// the sequence state and cp1252 lookup settle, and its character is loaded into
// the output register once the output is free. Output stall holds both stages.
module utf8_to_cp1252_decoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] text_byte,
    input  logic       last_in_text,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char
);
    import u8cp_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic        out_valid_reg;
    logic [7:0]  char_reg;
    logic        out_free;
    logic        advance;
    dec_result_t dec;
    map_result_t mapped;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;

    // Capture the request byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= text_byte;
            last_reg <= last_in_text;
        end
    end

    u8cp_decode u_decode
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .text_byte    (byte_reg),
        .last_in_text (last_reg),
        .result       (dec)
    );

    u8cp_map u_map
    (
        .dec    (dec),
        .result (mapped)
    );

    // Load the result when the output is free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && mapped.hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && mapped.hit)
        begin
            char_reg <= mapped.ch;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = char_reg;

endmodule

[test/utf8_to_cp1252_decoder_test.sv]
`timescale 1ns / 1ps

module utf8_to_cp1252_decoder_test;

    import u8cp_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_ITEMS = 1475;
    localparam int DRAIN_CYCLES = 20;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_stall;
    logic [7:0] text_byte    = 8'h00;
    logic       last_in_text = 1'b0;
    logic       out_valid;
    logic       out_stall    = 1'b0;
    logic [7:0] out_char;

    // Decoder state as the byte stream has left it
    logic [1:0]  pend_tails = TAILS_NONE;
    logic [15:0] pend_code  = '0;
    logic        pend_three = 1'b0;

    logic [7:0] expected_chars[$];

    int errors        = 0;
    int cycle_count   = 0;
    int bytes_sent    = 0;
    int burst_left    = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int stall_mode    = 0;
    int phase_left    = 0;

    utf8_to_cp1252_decoder DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .text_byte    (text_byte),
        .last_in_text (last_in_text),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_char     (out_char)
    );

    always #1 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Windows-1252 code of a code point, or -1 when it has none
    function automatic int cp1252_code(input logic [15:0] cp);
        if ((cp >= 16'd32 && cp <= 16'd126) || (cp >= 16'd160 && cp <= 16'd255))
            return int'(cp);
        if (cp == 16'd0)
            return -1;
        for (int k = 0; k < SPEC_COUNT; k++)
            if (SPEC_MAP[k] == cp)
                return 128 + k;
        return -1;
    endfunction

    // Advance the sequence state by one accepted byte and queue its character
    task automatic decode_byte(input logic [7:0] b, input logic last);
        logic        have;
        logic [15:0] cp;
        int          ch;
        have = 1'b0;
        cp   = '0;
        if (pend_tails == TAILS_NONE)
        begin
            if (b >= LEAD2_LO && b <= LEAD2_HI)
            begin
                pend_code  = {11'd0, b[4:0]};
                pend_tails = TAILS_ONE;
                pend_three = 1'b0;
            end
            else if (b >= LEAD3_LO && b <= LEAD3_HI)
            begin
                pend_code  = {12'd0, b[3:0]};
                pend_tails = TAILS_TWO;
                pend_three = 1'b1;
            end
            else if (!b[7])
            begin
                have = 1'b1;
                cp   = {8'd0, b};
            end
        end
        else if (b[7:6] != TAIL_MARK)
        begin
            pend_tails = TAILS_NONE;
            pend_code  = '0;
            pend_three = 1'b0;
        end
        else
        begin
            pend_code  = {pend_code[9:0], b[5:0]};
            pend_tails = pend_tails - 2'd1;
            if (pend_tails == TAILS_NONE)
            begin
                if (!(pend_three && pend_code < MIN_THREE))
                begin
                    have = 1'b1;
                    cp   = pend_code;
                end
                pend_code  = '0;
                pend_three = 1'b0;
            end
        end
        // Discard a sequence left open at the end of a text
        if (last && pend_tails != TAILS_NONE)
        begin
            pend_tails = TAILS_NONE;
            pend_code  = '0;
            pend_three = 1'b0;
        end
        if (have)
        begin
            ch = cp1252_code(cp);
            if (ch >= 0)
                expected_chars.push_back(ch[7:0]);
        end
    endtask

    // Offer one request in bursts with random gaps; called and returns at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid     <= 1'b1;
        text_byte    <= b;
        last_in_text <= last;
        do
            @(posedge clk);
        while (in_stall);
        decode_byte(b, last);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Encode a code point as one, two or three bytes; force_three gives three, overlong below 0x0800
    task automatic send_utf8(input logic [15:0] cp, input bit force_three);
        if (force_three || cp >= 16'h0800)
        begin
            send_byte({4'hE, cp[15:12]}, $urandom_range(0, 15) == 0);
            send_byte({2'b10, cp[11:6]}, $urandom_range(0, 15) == 0);
            send_byte({2'b10, cp[5:0]}, $urandom_range(0, 15) == 0);
        end
        else if (cp >= 16'h0080)
        begin
            send_byte({3'b110, cp[10:6]}, $urandom_range(0, 15) == 0);
            send_byte({2'b10, cp[5:0]}, $urandom_range(0, 15) == 0);
        end
        else
            send_byte(cp[7:0], $urandom_range(0, 15) == 0);
    endtask

    // Compare each delivered character with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_chars.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected out_char %02h", out_char);
            end
            else
            begin
                if (out_char !== expected_chars[0])
                begin
                    errors++;
                    if (errors <= 10)
                        $display("out_char mismatch: expected %02h, got %02h",
                                 expected_chars[0], out_char);
                end
                void'(expected_chars.pop_front());
            end
        end
    end

    // Receiver stall pattern, with long hold-offs on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            hold_left   <= LONG_HOLD;
            out_stall   <= 1'b1;
        end
        else
        begin
            if (phase_left == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                phase_left <= $urandom_range(16, 96);
            end
            else
                phase_left <= phase_left - 1;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 7) == 0);
                2: out_stall <= $urandom_range(0, 1);
                default: out_stall <= ~out_stall;
            endcase
        end
    end

    task automatic test_ascii_edges();
        send_byte(8'h00, 1'b0);
        send_byte(8'h1F, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h7E, 1'b0);
        send_byte(8'h7F, 1'b1);
    endtask

    task automatic test_multi_byte();
        // Two-byte: nbsp, y-diaeresis, unmappable C1 control
        send_utf8(16'h00A0, 1'b0);
        send_utf8(16'h00FF, 1'b0);
        send_utf8(16'h0080, 1'b0);
        // Three-byte euro sign, then an overlong form just under the minimum
        send_utf8(16'h20AC, 1'b0);
        send_byte(8'hE0, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'hBF, 1'b0);
    endtask

    task automatic test_stray_and_broken();
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        // Lead followed by a non-tail byte: both are consumed
        send_byte(8'hC3, 1'b0);
        send_byte(8'h41, 1'b0);
        // Text ends inside a sequence
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);
        send_byte(8'hAC, 1'b0);
    endtask

    // Hold the receiver off long enough for the block to stall its input
    task automatic test_backpressure();
        hold_requests++;
        for (int i = 0; i < 100; i++)
            send_utf8(16'(($urandom_range(0, 1) == 0) ? $urandom_range(32, 126)
                                                       : $urandom_range(160, 255)), 1'b0);
    endtask

    task automatic send_random_sequence();
        int          kind;
        logic [15:0] cp;
        logic [7:0]  junk;
        kind = $urandom_range(0, 99);
        if (kind < 30)
        begin
            // Mostly pass-through Latin-1 and the specials in their shortest form, plus other two-byte code points
            case ($urandom_range(0, 3))
                0, 1: cp = 16'($urandom_range(160, 255));
                2: cp = SPEC_MAP[$urandom_range(0, SPEC_COUNT - 1)];
                default: cp = 16'($urandom_range(128, 2047));
            endcase
            send_utf8(cp, 1'b0);
        end
        else if (kind < 60)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: cp = SPEC_MAP[$urandom_range(0, SPEC_COUNT - 1)];
                4, 5: cp = 16'($urandom_range(2048, 65535));
                6: cp = 16'($urandom_range(0, 2047));
                7: cp = 16'($urandom_range(2032, 2064));
                default: cp = 16'($urandom_range(0, 65535));
            endcase
            send_utf8(cp, 1'b1);
        end
        else if (kind < 75)
            send_byte(8'($urandom_range(0, 127)), $urandom_range(0, 15) == 0);
        else if (kind < 85)
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        else
        begin
            // Open a sequence, maybe add a tail, then end it with a tail marked last or break it with a non-tail byte
            send_byte(8'($urandom_range(LEAD2_LO, LEAD3_HI)), 1'b0);
            if ($urandom_range(0, 1) == 0)
                send_byte({2'b10, 6'($urandom_range(0, 63))}, 1'b0);
            if ($urandom_range(0, 2) == 0)
                send_byte({2'b10, 6'($urandom_range(0, 63))}, 1'b1);
            else
            begin
                junk = 8'($urandom_range(0, 191));
                if (junk[7:6] == TAIL_MARK)
                    junk = junk ^ 8'h40;
                send_byte(junk, $urandom_range(0, 15) == 0);
            end
        end
    endtask

    task automatic test_random();
        int start_count;
        start_count = bytes_sent;
        while (bytes_sent - start_count < RANDOM_ITEMS)
            send_random_sequence();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_ascii_edges();
        test_multi_byte();
        test_stray_and_broken();
        test_backpressure();
        test_random();

        // Drain outstanding characters
        in_valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && expected_chars.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/u8cp_pkg.sv
rtl/core/u8cp_decode.sv
rtl/core/u8cp_map.sv
rtl/core/utf8_to_cp1252_decoder.sv
test/utf8_to_cp1252_decoder_test.sv
